// File: hw/rtl/u8250_pkg.sv
// Shared types and constants for the 8250 UART register model.
// Transaction payload structs, command codes, register offsets and status bits.
// No dependencies.
package u8250_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [2:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] rx_byte;
    logic       rx_parity_bad;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq_line;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic [15:0] baud_divisor;
  } out_item_t;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_RX     = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_RBR = 3'd0;
  localparam logic [2:0] REG_IER = 3'd1;
  localparam logic [2:0] REG_IIR = 3'd2;
  localparam logic [2:0] REG_LCR = 3'd3;
  localparam logic [2:0] REG_MCR = 3'd4;
  localparam logic [2:0] REG_LSR = 3'd5;
  localparam logic [2:0] REG_MSR = 3'd6;
  localparam logic [2:0] REG_SCR = 3'd7;

  localparam logic [7:0] LCR_RESET  = 8'h03;
  localparam int unsigned LCR_DLAB_BIT = 7;
  localparam int unsigned FCR_RXCLR_BIT = 1;

  // pending bit positions
  localparam int unsigned PEND_RDA  = 0;
  localparam int unsigned PEND_THRE = 1;
  localparam int unsigned PEND_RLS  = 2;

  localparam logic [7:0] IIR_RLS  = 8'h06;
  localparam logic [7:0] IIR_RDA  = 8'h04;
  localparam logic [7:0] IIR_THRE = 8'h02;
  localparam logic [7:0] IIR_NONE = 8'h01;

  localparam logic [15:0] DIV_RESET = 16'd1;

endpackage

// File: hw/rtl/u8250_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module u8250_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/uart_8250_register_model.sv
// Each accepted transaction's result is registered in out_r (or skid_r if stalled).
// Throughput: one transaction per cycle unless in_stall; a two-entry output stage
// (output register plus skid) keeps accepting while one result waits on out_stall.
// Reset (synchronous, rst_n low): LCR 0x03, LSR 0x60 (THRE, TEMT), divisor and
// default divisor 1, pending, enables and modem registers zero, receive FIFO empty.
// Depends on u8250_pkg and u8250_ram.
module uart_8250_register_model
  import u8250_pkg::*;
#(
  parameter int RX_DEPTH = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int AW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int CW = $clog2(RX_DEPTH + 1);

  // architectural state
  logic [15:0]   dflt_div_r;
  logic [7:0]    lcr_r, lcr_nxt;
  logic [3:0]    ier_r, ier_nxt;
  logic          oe_r, oe_nxt;
  logic          pe_r, pe_nxt;
  logic [2:0]    pend_r, pend_nxt;
  logic [15:0]   div_r, div_nxt;
  logic [7:0]    mcr_r, mcr_nxt;
  logic [7:0]    msr_r, msr_nxt;
  logic [7:0]    scr_r, scr_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // head-of-FIFO read path
  logic          byp_r;
  logic [7:0]    byp_data_r;
  logic [7:0]    ram_rdata;
  logic [7:0]    head_data;
  logic          push;
  logic [AW-1:0] tail;
  logic [AW:0]   tail_sum;

  // output stage
  logic          out_v_r, skid_v_r;
  out_item_t     out_r, skid_r;
  out_item_t     res;
  logic          in_fire, out_fire;

  assign in_stall  = skid_v_r;
  assign in_fire   = in_valid & ~skid_v_r;
  assign out_fire  = out_v_r & ~out_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign head_data = byp_r ? byp_data_r : ram_rdata;

  always_comb begin
    tail_sum = {1'b0, head_r} + (AW+1)'(cnt_r);
    if (tail_sum >= (AW+1)'(RX_DEPTH)) begin
      tail_sum = tail_sum - (AW+1)'(RX_DEPTH);
    end
    tail = tail_sum[AW-1:0];
  end

  function automatic logic [15:0] fix_div(input logic [15:0] d, input logic [15:0] dflt);
    logic [15:0] r;
    r = d;
    if (d == '0) begin
      r = (dflt == '0) ? DIV_RESET : dflt;
    end
    return r;
  endfunction

  always_comb begin
    logic recomp;
    logic dlab;
    recomp   = 1'b0;
    dlab     = lcr_r[LCR_DLAB_BIT];
    lcr_nxt  = lcr_r;
    ier_nxt  = ier_r;
    oe_nxt   = oe_r;
    pe_nxt   = pe_r;
    pend_nxt = pend_r;
    div_nxt  = div_r;
    mcr_nxt  = mcr_r;
    msr_nxt  = msr_r;
    scr_nxt  = scr_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    res      = '0;

    if (in_fire) begin
      unique case (in_data.command)
        CMD_READ: begin
          unique case (in_data.reg_addr)
            REG_RBR: begin
              if (dlab) begin
                res.read_data = div_r[7:0];
              end else if (cnt_r != '0) begin
                res.read_data = head_data;
                head_nxt = (head_r == AW'(RX_DEPTH - 1)) ? '0 : head_r + 1'b1;
                cnt_nxt  = cnt_r - 1'b1;
                recomp   = 1'b1;
              end
            end
            REG_IER: res.read_data = dlab ? div_r[15:8] : {4'b0, ier_r};
            REG_IIR: begin
              if (pend_r[PEND_RLS]) begin
                res.read_data = IIR_RLS;
              end else if (pend_r[PEND_RDA]) begin
                res.read_data = IIR_RDA;
              end else if (pend_r[PEND_THRE]) begin
                res.read_data = IIR_THRE;
                pend_nxt[PEND_THRE] = 1'b0;
              end else begin
                res.read_data = IIR_NONE;
              end
            end
            REG_LCR: res.read_data = lcr_r;
            REG_MCR: res.read_data = mcr_r;
            REG_LSR: begin
              res.read_data = {2'b01, 1'b1, 2'b00, pe_r, oe_r, (cnt_r != '0)};
              oe_nxt = 1'b0;
              pe_nxt = 1'b0;
              recomp = 1'b1;
            end
            REG_MSR: res.read_data = msr_r;
            REG_SCR: res.read_data = scr_r;
          endcase
        end
        CMD_WRITE: begin
          unique case (in_data.reg_addr)
            REG_RBR: begin
              if (dlab) begin
                div_nxt = fix_div({div_r[15:8], in_data.write_data}, dflt_div_r);
              end else begin
                res.tx_valid = 1'b1;
                res.tx_char  = in_data.write_data;
                recomp       = 1'b1;
              end
            end
            REG_IER: begin
              if (dlab) begin
                div_nxt = fix_div({in_data.write_data, div_r[7:0]}, dflt_div_r);
              end else begin
                ier_nxt = in_data.write_data[3:0];
                recomp  = 1'b1;
              end
            end
            REG_IIR: begin
              if (in_data.write_data[FCR_RXCLR_BIT]) begin
                cnt_nxt  = '0;
                head_nxt = '0;
                recomp   = 1'b1;
              end
            end
            REG_LCR: lcr_nxt = in_data.write_data;
            REG_MCR: mcr_nxt = in_data.write_data;
            REG_LSR: ;
            REG_MSR: msr_nxt = in_data.write_data;
            REG_SCR: scr_nxt = in_data.write_data;
          endcase
        end
        CMD_RX: begin
          if (cnt_r < CW'(RX_DEPTH)) begin
            push    = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (in_data.rx_parity_bad) begin
              pe_nxt = 1'b1;
            end
          end else begin
            oe_nxt = 1'b1;
          end
          recomp = 1'b1;
        end
        default: ;
      endcase
    end

    if (recomp) begin
      pend_nxt = '0;
      pend_nxt[PEND_THRE] = 1'b1;
      pend_nxt[PEND_RDA]  = (cnt_nxt != '0);
      pend_nxt[PEND_RLS]  = oe_nxt;
    end

    res.irq_line     = |({1'b0, pend_nxt} & ier_nxt);
    res.baud_divisor = div_nxt;
  end

  u8250_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH),
    .AW    (AW)
  ) u_rx_ram (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (tail),
    .wr_data (in_data.rx_byte),
    .rd_addr (head_nxt),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_div_r <= DIV_RESET;
      lcr_r      <= LCR_RESET;
      ier_r      <= '0;
      oe_r       <= 1'b0;
      pe_r       <= 1'b0;
      pend_r     <= '0;
      div_r      <= DIV_RESET;
      mcr_r      <= '0;
      msr_r      <= '0;
      scr_r      <= '0;
      head_r     <= '0;
      cnt_r      <= '0;
      byp_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dflt_div_r <= cfg_wr_data;
      end
      lcr_r  <= lcr_nxt;
      ier_r  <= ier_nxt;
      oe_r   <= oe_nxt;
      pe_r   <= pe_nxt;
      pend_r <= pend_nxt;
      div_r  <= div_nxt;
      mcr_r  <= mcr_nxt;
      msr_r  <= msr_nxt;
      scr_r  <= scr_nxt;
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
      byp_r  <= push && (tail == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= in_data.rx_byte;
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (!out_v_r || out_fire) begin
        out_v_r  <= skid_v_r | in_fire;
        skid_v_r <= 1'b0;
      end else if (in_fire) begin
        skid_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_fire) begin
      out_r <= skid_v_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid entry holds a transaction while output register is empty");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(RX_DEPTH))
    else $error("receive FIFO count exceeds depth");

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_r != '0)
    else $error("divisor latch is zero");

  a_oe_pending: assert property (@(posedge clk) disable iff (!rst_n)
    oe_r |-> pend_r[PEND_RLS])
    else $error("overrun set without line status interrupt pending");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |=> (out_v_r && $stable(out_r)))
    else $error("stalled result changed");
`endif

endmodule
